// ----- sv/l2xy_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package l2xy_pkg;

  // sizing
  localparam int RANGE_BITS    = 20;
  localparam int CORDIC_STAGES = 18;
  localparam int MAX_SAMPLES   = 4096;

  // fixed point
  localparam int GUARD     = 12;
  localparam int GAIN_W    = 31;
  localparam logic [GAIN_W-1:0] GAIN_INV = 31'h4DBA76D4;
  localparam int PROD_W    = RANGE_BITS + GAIN_W;
  localparam int SCALE_SH  = GAIN_W - GUARD;
  localparam int SCALED_W  = PROD_W + 1 - SCALE_SH;
  localparam int XY_W      = RANGE_BITS + GUARD + 3;
  localparam int Z_W       = 34;
  localparam int ANGLE_W   = 32;
  localparam int STG_W     = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  // output fields
  localparam int COORD_W   = 21;
  localparam int IDX_W     = 12;
  localparam int OUT_LIMIT = 1048575;
  localparam int INDEX_LIMIT = (MAX_SAMPLES > 4096) ? 4095 : (MAX_SAMPLES - 1);

  // stream packing
  localparam int IN_DATA_W  = ((RANGE_BITS + 7) / 8) * 8;
  localparam int OUT_FLD_W  = 2 * COORD_W + IDX_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // register map (word index)
  localparam logic [1:0] REG_START_ANGLE = 2'd0;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [1:0] REG_RANGE_LOW   = 2'd2;
  localparam logic [1:0] REG_RANGE_HIGH  = 2'd3;

  typedef struct packed {
    logic [ANGLE_W-1:0]    start_angle;
    logic [ANGLE_W-1:0]    angle_step;
    logic [RANGE_BITS-1:0] range_low;
    logic [RANGE_BITS-1:0] range_high;
  } cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [IDX_W-1:0]       idx;
  } cordic_word_t;

  // arctangent of 2^-i in binary angle units
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      5'd24:   a = 32'd41;
      5'd25:   a = 32'd20;
      5'd26:   a = 32'd10;
      5'd27:   a = 32'd5;
      5'd28:   a = 32'd3;
      5'd29:   a = 32'd1;
      5'd30:   a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- sv/l2xy_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module l2xy_front import l2xy_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [RANGE_BITS-1:0] range_i,
  input  logic                  start_i,
  input  cfg_t                  cfg_i,
  output logic                  vld_o,
  output cordic_word_t          word_o
);

  logic                  accept;
  logic [ANGLE_W-1:0]    ang_sel;
  logic [IDX_W-1:0]      idx_sel;
  logic                  gate;

  logic [ANGLE_W-1:0]    beam_q, beam_d;
  logic [IDX_W-1:0]      cnt_q, cnt_d;

  logic                  a_vld_q;
  logic [RANGE_BITS-1:0] a_r_q;
  logic [ANGLE_W-1:0]    a_ang_q;
  logic [IDX_W-1:0]      a_idx_q;

  logic                  b_vld_q;
  logic [PROD_W-1:0]     b_prod_q;
  logic [ANGLE_W-1:0]    b_ang_q;
  logic [IDX_W-1:0]      b_idx_q;

  logic                  c_vld_q;
  cordic_word_t          c_word_q, c_word_d;

  logic [PROD_W:0]         sum;
  logic [SCALED_W-1:0]     scaled;
  logic signed [XY_W-1:0]  x_pos;
  logic                    fold;
  logic signed [ANGLE_W-1:0] z_fold;

  // beam angle and index for this word
  assign accept  = valid_i & en_i;
  assign ang_sel = start_i ? cfg_i.start_angle : beam_q;
  assign idx_sel = start_i ? '0 : cnt_q;
  assign gate    = (range_i > cfg_i.range_low) && (range_i < cfg_i.range_high);
  assign beam_d  = ang_sel + cfg_i.angle_step;
  assign cnt_d   = (idx_sel < IDX_W'(INDEX_LIMIT)) ? idx_sel + IDX_W'(1) : idx_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      beam_q <= beam_d;
      cnt_q  <= cnt_d;
    end
  end

  // gain scaling, rounding and quadrant fold
  assign sum    = {1'b0, b_prod_q} + (PROD_W+1)'(1 << (SCALE_SH - 1));
  assign scaled = sum[PROD_W:SCALE_SH];
  assign x_pos  = $signed(XY_W'(scaled));
  assign fold   = b_ang_q[ANGLE_W-1] ^ b_ang_q[ANGLE_W-2];
  assign z_fold = $signed({b_ang_q[ANGLE_W-1] ^ fold, b_ang_q[ANGLE_W-2:0]});

  always_comb begin
    c_word_d.x   = fold ? -x_pos : x_pos;
    c_word_d.y   = '0;
    c_word_d.z   = Z_W'(z_fold);
    c_word_d.idx = b_idx_q;
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= accept & gate;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_r_q    <= range_i;
      a_ang_q  <= ang_sel;
      a_idx_q  <= idx_sel;
      b_prod_q <= PROD_W'(a_r_q) * PROD_W'(GAIN_INV);
      b_ang_q  <= a_ang_q;
      b_idx_q  <= a_idx_q;
      c_word_q <= c_word_d;
    end
  end

  assign vld_o  = c_vld_q;
  assign word_o = c_word_q;

endmodule

`default_nettype wire

// ----- sv/l2xy_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module l2xy_cell import l2xy_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [STG_W-1:0] stage_i,
  input  logic             vld_i,
  input  cordic_word_t     word_i,
  output logic             vld_o,
  output cordic_word_t     word_o
);

  logic                   vld_q;
  cordic_word_t           word_q, word_d;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  at;
  logic                   pos;

  // one micro-rotation
  assign dx  = word_i.y >>> stage_i;
  assign dy  = word_i.x >>> stage_i;
  assign at  = $signed({{(Z_W-32){1'b0}}, atan_lut(5'(stage_i))});
  assign pos = ~word_i.z[Z_W-1];

  always_comb begin
    word_d.idx = word_i.idx;
    if (pos) begin
      word_d.x = word_i.x - dx;
      word_d.y = word_i.y + dy;
      word_d.z = word_i.z - at;
    end else begin
      word_d.x = word_i.x + dx;
      word_d.y = word_i.y - dy;
      word_d.z = word_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

`default_nettype wire

// ----- sv/l2xy_out.sv -----
`timescale 1ns / 1ps
`default_nettype none

module l2xy_out import l2xy_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  cordic_word_t          word_i,
  input  logic                  ready_i,
  output logic                  adv_o,
  output logic                  vld_o,
  output logic [OUT_DATA_W-1:0] data_o
);

  localparam int RW = XY_W + 1;
  localparam logic signed [RW-1:0] LimP = RW'(OUT_LIMIT);
  localparam logic signed [RW-1:0] LimN = -LimP;

  logic                  vld_q;
  logic [COORD_W-1:0]    px_q, py_q, px_d, py_d;
  logic [IDX_W-1:0]      idx_q;
  logic signed [RW-1:0]  vx, vy, rx, ry;

  // round half up and clamp
  assign vx = RW'(word_i.x) + RW'(1 << (GUARD - 1));
  assign vy = RW'(word_i.y) + RW'(1 << (GUARD - 1));
  assign rx = vx >>> GUARD;
  assign ry = vy >>> GUARD;

  always_comb begin
    if (rx > LimP)      px_d = COORD_W'(LimP);
    else if (rx < LimN) px_d = COORD_W'(LimN);
    else                px_d = COORD_W'(rx);
    if (ry > LimP)      py_d = COORD_W'(LimP);
    else if (ry < LimN) py_d = COORD_W'(LimN);
    else                py_d = COORD_W'(ry);
  end

  // output register, the chain moves when it is free
  assign adv_o = ~vld_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && vld_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      idx_q <= word_i.idx;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = OUT_DATA_W'({idx_q, py_q, px_q});

endmodule

`default_nettype wire

// ----- sv/laser_scan_polar_to_xy.sv -----
// Laser scan polar to cartesian converter.
// s_axis carries one range sample per word: tdata holds range_sample, tuser
// holds scan_start, which reloads the beam angle with start_angle and the
// beam index with zero for that sample. Every accepted sample advances the
// angle by angle_step and the saturating index by one.
// Samples with range_low < range < range_high give one word on m_axis with
// x = r cos(angle), y = r sin(angle) and the beam index; others give none.
// The pipeline has three front stages (angle and gate, gain multiply,
// scaling and quadrant fold), one cell per CORDIC micro-rotation, then the
// rounding output register.
// Throughput is one sample per cycle; the whole chain moves together, so
// when m_axis stalls with a word held, s_axis tready drops in that cycle and
// every stage holds until the word is taken.
// The APB port writes registers at byte address 4*i and reads them back.
// Reset clears the pipeline, the beam angle and index, and sets the
// registers to start_angle 0, angle_step 0, range_low 0, range_high all ones.
`timescale 1ns / 1ps
`default_nettype none

module laser_scan_polar_to_xy import l2xy_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // samples
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // range_sample
  input  logic                  s_axis_tuser,  // scan_start
  // points
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // point_x, point_y, beam_index
);

  cfg_t         cfg_q;
  logic         wr_en;
  logic         adv;

  logic         vld   [CORDIC_STAGES+1];
  cordic_word_t word  [CORDIC_STAGES+1];

  // register file
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle <= '0;
      cfg_q.angle_step  <= '0;
      cfg_q.range_low   <= '0;
      cfg_q.range_high  <= '1;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_START_ANGLE: cfg_q.start_angle <= pwdata;
        REG_ANGLE_STEP:  cfg_q.angle_step  <= pwdata;
        REG_RANGE_LOW:   cfg_q.range_low   <= RANGE_BITS'(pwdata);
        REG_RANGE_HIGH:  cfg_q.range_high  <= RANGE_BITS'(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START_ANGLE: prdata = cfg_q.start_angle;
      REG_ANGLE_STEP:  prdata = cfg_q.angle_step;
      REG_RANGE_LOW:   prdata = 32'(cfg_q.range_low);
      REG_RANGE_HIGH:  prdata = 32'(cfg_q.range_high);
      default:         prdata = '0;
    endcase
  end

  assign s_axis_tready = adv;

  // angle tracking, gate and gain scaling
  l2xy_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .range_i (s_axis_tdata[RANGE_BITS-1:0]),
    .start_i (s_axis_tuser),
    .cfg_i   (cfg_q),
    .vld_o   (vld[0]),
    .word_o  (word[0])
  );

  // chain of rotation cells
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    l2xy_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (STG_W'(g)),
      .vld_i   (vld[g]),
      .word_i  (word[g]),
      .vld_o   (vld[g+1]),
      .word_o  (word[g+1])
    );
  end

  // rounding and output register
  l2xy_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (vld[CORDIC_STAGES]),
    .word_i  (word[CORDIC_STAGES]),
    .ready_i (m_axis_tready),
    .adv_o   (adv),
    .vld_o   (m_axis_tvalid),
    .data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // a held word stalls the input side
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output word is stalled");

  // scan start restarts the index from zero
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> u_front.cnt_q == IDX_W'(1))
    else $error("beam index did not restart on scan start");

  // index never passes its limit
  a_idx_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_front.cnt_q <= IDX_W'(INDEX_LIMIT))
    else $error("beam index above limit");

  // clamped coordinates never reach the most negative code
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[COORD_W-1:0] != {1'b1, {(COORD_W-1){1'b0}}}
                   && m_axis_tdata[2*COORD_W-1:COORD_W] != {1'b1, {(COORD_W-1){1'b0}}})
    else $error("coordinate outside clamp range");
`endif

endmodule

`default_nettype wire

// ----- tb/l2xy_point_checker.sv -----
`timescale 1ns / 1ps

module l2xy_point_checker import l2xy_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [3:0]            paddr_i,
  input  logic [31:0]           pwdata_i,
  input  logic [31:0]           prdata_i,
  input  logic                  pready_i,
  // samples
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,   // range_sample
  input  logic                  s_tuser_i,   // scan_start
  // points
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,   // point_x, point_y, beam_index
  // status for the test top
  output int                    errors_o,
  output int                    pending_o,
  output int                    samples_o,
  output int                    points_o
);

  localparam int     STAGES    = 18;
  localparam int     FRAC_BITS = 12;
  localparam longint GAIN_K    = 64'h4DBA76D4;
  localparam longint XY_LIMIT  = 1048575;
  localparam int     IDX_MAX   = 4095;

  // micro-rotation angles, atan(2^-i) in binary angle units
  localparam longint ATAN_TAB [STAGES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215
  };

  typedef struct {
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic [11:0]        idx;
  } point_t;

  point_t      point_q [$];
  logic [31:0] start_angle_q;
  logic [31:0] angle_step_q;
  logic [19:0] range_low_q;
  logic [19:0] range_high_q;
  logic [31:0] beam_angle;
  logic [11:0] beam_count;

  // round half up from the guard bits, then clamp to the coordinate range
  function automatic logic signed [20:0] round_clamp(input longint v);
    longint r;
    r = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > XY_LIMIT) r = XY_LIMIT;
    if (r < -XY_LIMIT) r = -XY_LIMIT;
    return r[20:0];
  endfunction

  // gain-compensated rotation of (r, 0) by the beam angle
  function automatic point_t polar_to_xy(input logic [19:0] r, input logic [31:0] ang,
                                         input logic [11:0] idx);
    point_t      p;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    logic [31:0] a;
    x = (longint'(r) * GAIN_K + (longint'(1) << (30 - FRAC_BITS))) >>> (31 - FRAC_BITS);
    y = 0;
    a = ang;
    // fold the left half plane onto the right one
    if (((a + 32'h4000_0000) & 32'h8000_0000) != 32'h0) begin
      x = -x;
      a = a - 32'h8000_0000;
    end
    z = longint'($signed(a));
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end
    end
    p.x   = round_clamp(x);
    p.y   = round_clamp(y);
    p.idx = idx;
    return p;
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_START_ANGLE: return start_angle_q;
      REG_ANGLE_STEP:  return angle_step_q;
      REG_RANGE_LOW:   return {12'h0, range_low_q};
      REG_RANGE_HIGH:  return {12'h0, range_high_q};
      default:         return 32'h0;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t             want;
    logic [19:0]        r;
    logic signed [20:0] got_x;
    logic signed [20:0] got_y;
    logic [11:0]        got_idx;
    if (!rst_ni) begin
      point_q.delete();
      start_angle_q = 32'h0;
      angle_step_q  = 32'h0;
      range_low_q   = 20'h0;
      range_high_q  = 20'hFFFFF;
      beam_angle    = 32'h0;
      beam_count    = 12'h0;
      errors_o      = 0;
      pending_o     = 0;
      samples_o     = 0;
      points_o      = 0;
    end else begin
      // register writes and read-back
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          case (paddr_i[3:2])
            REG_START_ANGLE: start_angle_q = pwdata_i;
            REG_ANGLE_STEP:  angle_step_q  = pwdata_i;
            REG_RANGE_LOW:   range_low_q   = pwdata_i[19:0];
            REG_RANGE_HIGH:  range_high_q  = pwdata_i[19:0];
            default: ;
          endcase
        end else if (prdata_i !== reg_value(paddr_i[3:2])) begin
          $error("prdata mismatch at 0x%0h: expected 0x%08h, got 0x%08h",
                 paddr_i, reg_value(paddr_i[3:2]), prdata_i);
          errors_o++;
        end
      end

      // sample word: angle and index advance whether or not it is gated out
      if (s_tvalid_i && s_tready_i) begin
        r = s_tdata_i[19:0];
        if (s_tuser_i) begin
          beam_angle = start_angle_q;
          beam_count = 12'h0;
        end
        if (r > range_low_q && r < range_high_q)
          point_q.insert(point_q.size(), polar_to_xy(r, beam_angle, beam_count));
        beam_angle = beam_angle + angle_step_q;
        if (beam_count < IDX_MAX) beam_count = beam_count + 12'd1;
        samples_o++;
      end

      // point word against the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        got_x   = m_tdata_i[20:0];
        got_y   = m_tdata_i[41:21];
        got_idx = m_tdata_i[53:42];
        if (point_q.size() == 0) begin
          $error("unexpected point word: x %0d, y %0d, index %0d", got_x, got_y, got_idx);
          errors_o++;
        end else begin
          want = point_q.pop_front();
          if (got_x !== want.x) begin
            $error("point_x mismatch: expected %0d, got %0d", want.x, got_x);
            errors_o++;
          end
          if (got_y !== want.y) begin
            $error("point_y mismatch: expected %0d, got %0d", want.y, got_y);
            errors_o++;
          end
          if (got_idx !== want.idx) begin
            $error("beam_index mismatch: expected %0d, got %0d", want.idx, got_idx);
            errors_o++;
          end
          points_o++;
        end
      end
      pending_o = point_q.size();
    end
  end

endmodule

// ----- tb/laser_scan_polar_to_xy_tb.sv -----
`timescale 1ns / 1ps

module laser_scan_polar_to_xy_tb;
  import l2xy_pkg::*;

  localparam int     HOLD_CYCLES = 400;
  localparam int     SETTLE      = 50;
  localparam int     LONG_SCAN   = 500;
  localparam longint LIMIT_NS    = 64'd16_000_000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [3:0]            paddr         = 4'h0;
  logic [31:0]           pwdata        = 32'h0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // range_sample
  logic                  s_axis_tuser  = 1'b0;  // scan_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;          // point_x, point_y, beam_index

  int          fail_count;
  int          pending;
  int          n_samples;
  int          n_points;
  int          n_settings = 0;
  logic        tx_gaps    = 1'b1;
  logic        rx_stalls  = 1'b1;
  logic        hold_req   = 1'b0;
  logic        hold_done  = 1'b0;
  logic [19:0] cur_lo     = 20'h0;
  logic [19:0] cur_hi     = 20'hFFFFF;

  laser_scan_polar_to_xy DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  l2xy_point_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .prdata_i   (prdata),
    .pready_i   (pready),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .errors_o   (fail_count),
    .pending_o  (pending),
    .samples_o  (n_samples),
    .points_o   (n_points)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_NS);
    $display("laser_scan_polar_to_xy test failed");
    $finish;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    else if (p < 93) return $urandom_range(3, 1);
    else return $urandom_range(30, 8);
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hC000_0000;
      3:       return 32'h4000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly inside the gate, some on its edges, the rest anywhere
  function automatic logic [19:0] pick_range();
    int p;
    p = $urandom_range(99);
    if (p < 70 && cur_hi > cur_lo + 1) return 20'($urandom_range(cur_hi - 1, cur_lo + 1));
    if (p < 85) begin
      case ($urandom_range(3))
        0:       return cur_lo;
        1:       return cur_lo + 20'd1;
        2:       return cur_hi - 20'd1;
        default: return cur_hi;
      endcase
    end
    return 20'($urandom);
  endfunction

  // one sample word, then a random gap on the sender side
  task automatic send_sample(input logic [19:0] r, input logic st);
    int n;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(r);
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    n = tx_gaps ? idle_len() : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // apb write, then read back through the checker
  task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] sa, input logic [31:0] st,
                               input logic [19:0] lo, input logic [19:0] hi);
    set_reg(REG_START_ANGLE, sa);
    set_reg(REG_ANGLE_STEP, st);
    set_reg(REG_RANGE_LOW, {12'h0, lo});
    set_reg(REG_RANGE_HIGH, {12'h0, hi});
    cur_lo = lo;
    cur_hi = hi;
    n_settings++;
  endtask

  // stop offering, let every point arrive and gated-out samples flush
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // scans of random length, each opened by a scan start, with a few stray starts
  task automatic run_scans(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(4, 1) : $urandom_range(300, 16);
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_sample(pick_range(), (k == 0) || ($urandom_range(49) == 0));
        sent++;
      end
    end
  endtask

  // receiver: random stalls, a stall-free mode, and one long hold-off
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!rx_stalls) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = idle_len();
        m_axis_tready <= (n == 0);
        repeat ((n == 0) ? 1 : n) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [31:0] step;
    logic [19:0] lo;
    logic [19:0] hi;
    int          p;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no scan start since reset: angle 0, index from 0, default gate edges
    send_sample(20'h00000, 1'b0);
    send_sample(20'h00001, 1'b0);
    send_sample(20'hFFFFE, 1'b0);
    send_sample(20'hFFFFF, 1'b0);
    send_sample(20'h55555, 1'b0);
    send_sample(20'hAAAAA, 1'b0);
    drain();

    // eighth-turn steps at full range, through every octant and the wrap
    apply_setting(32'h0000_0000, 32'h2000_0000, 20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFE, 1'b1);
    for (int k = 0; k < 9; k++) send_sample(20'hFFFFE, 1'b0);
    drain();

    // empty gate: nothing comes out, angle and index still move
    apply_setting(32'h7FFF_FFFF, 32'h8000_0000, 20'hFFFFF, 20'h00000);
    send_sample(20'h00000, 1'b1);
    send_sample(20'hFFFFF, 1'b0);
    send_sample(20'h80000, 1'b0);
    send_sample(20'h00001, 1'b0);
    drain();

    // narrow gate, both edges excluded, restart mid-scan
    apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 20'd100, 20'd200);
    send_sample(20'd100, 1'b1);
    send_sample(20'd101, 1'b0);
    send_sample(20'd199, 1'b0);
    send_sample(20'd200, 1'b0);
    send_sample(20'd150, 1'b1);
    drain();

    // random settings, scans with random content
    for (int ph = 0; ph < 8; ph++) begin
      tx_gaps   = (ph % 3 != 1);
      rx_stalls = (ph % 4 != 2);
      p = $urandom_range(9);
      if (p < 2) step = (p == 0) ? 32'h0 : 32'hFFFF_FFFF;
      else if (p < 5) step = $urandom;
      else begin
        step = $urandom_range(32'h0100_0000, 1);
        if ($urandom_range(1) != 0) step = -step;
      end
      p = $urandom_range(99);
      if (p < 60) begin
        lo = 20'($urandom_range(4096, 0));
        hi = 20'($urandom_range(20'hFFFFF, lo + 2));
      end else if (p < 75) begin
        lo = 20'h00000;
        hi = 20'hFFFFF;
      end else if (p < 85) begin
        lo = 20'($urandom);
        hi = 20'($urandom);
      end else begin
        lo = 20'($urandom);
        hi = lo + 20'($urandom_range(64, 2));
      end
      apply_setting(pick_angle(), step, lo, hi);
      run_scans(180);
      drain();
    end

    // one long scan, with a long output hold-off early on
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    apply_setting(pick_angle(), 32'd5965232, 20'h00000, 20'hFFFFF);
    hold_req = 1'b1;
    for (int k = 0; k < LONG_SCAN; k++) send_sample(pick_range(), k == 0);
    drain();

    $display("covered %0d samples and %0d points over %0d register settings,",
             n_samples, n_points, n_settings);
    $display("including an empty gate, gate edges and a %0d-cycle output hold",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("laser_scan_polar_to_xy test passed");
    end else begin
      $display("laser_scan_polar_to_xy test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/l2xy_pkg.sv
sv/l2xy_front.sv
sv/l2xy_cell.sv
sv/l2xy_out.sv
sv/laser_scan_polar_to_xy.sv
tb/l2xy_point_checker.sv
tb/laser_scan_polar_to_xy_tb.sv
